FILE: design/sfcd_pkg.sv
// Shared types and constants for the sync-framed command deframer.
// No dependencies; imported by sfcd_decode and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 7;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // register reset values
  localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'd79;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'd75;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_SYNC  = 1'b0;
  localparam logic REG_SECOND_SYNC = 1'b1;

  // command map
  localparam logic [BYTE_W-1:0] CMD_LIMIT        = 8'd100;
  localparam logic [CMD_W-1:0]  SENSOR_SLOTS     = 7'd12;
  localparam logic [CMD_W-1:0]  FLIGHT_STATE_CMD = 7'd12;
  localparam logic [CMD_W-1:0]  GAIN_FIRST_CMD   = 7'd13;
  localparam logic [CMD_W-1:0]  GAIN_LAST_CMD    = 7'd21;
  localparam logic [CMD_W-1:0]  MOTOR_FIRST_CMD  = 7'd23;
  localparam logic [CMD_W-1:0]  MOTOR_LAST_CMD   = 7'd24;

  // IEEE single bit pattern of 5000.0
  localparam logic [31:0] MAG_LIMIT_BITS = 32'h459C_4000;

  typedef enum logic [2:0] {
    KIND_SENSOR = 3'd0,
    KIND_REJECT = 3'd1,
    KIND_FLIGHT = 3'd2,
    KIND_GAIN   = 3'd3,
    KIND_MOTOR  = 3'd4,
    KIND_NONE   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t               write_kind;
    logic [3:0]          target_index;
    logic [31:0]         float_bits;
    logic [15:0]         first_word;
    logic [15:0]         second_word;
    logic [BYTE_W-1:0]   first_byte;
    logic [COUNT_W-1:0]  accepted_count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/sfcd_decode.sv
// Frame decode: turns command and four payload bytes into one write record.
// Depends on sfcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_decode
  import sfcd_pkg::*;
(
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [23:0]        payload,     // bytes 0..2, byte 0 low
  input  wire logic [BYTE_W-1:0]  last_byte,   // byte 3
  input  wire logic [COUNT_W-1:0] count,
  output result_t                 result
);

  logic [BYTE_W-1:0] b0, b1, b2;
  logic [31:0]       fbits;
  logic [CMD_W-1:0]  gain_idx, motor_idx;

  assign b0        = payload[7:0];
  assign b1        = payload[15:8];
  assign b2        = payload[23:16];
  assign fbits     = {last_byte, b2, b1, b0};
  assign gain_idx  = cmd - GAIN_FIRST_CMD;
  assign motor_idx = cmd - MOTOR_FIRST_CMD;

  always_comb begin
    result                = '0;
    result.write_kind     = KIND_NONE;
    result.accepted_count = count + COUNT_W'(1);
    if (cmd < SENSOR_SLOTS) begin
      result.float_bits   = fbits;
      result.target_index = cmd[3:0];
      // magnitude test on the bit pattern: NaN and infinity fail too
      if ({1'b0, fbits[30:0]} < MAG_LIMIT_BITS) begin
        result.write_kind = KIND_SENSOR;
      end else begin
        result.write_kind     = KIND_REJECT;
        result.accepted_count = count;
      end
    end else if (cmd == FLIGHT_STATE_CMD) begin
      result.write_kind = KIND_FLIGHT;
      result.first_byte = b0;
    end else if (cmd >= GAIN_FIRST_CMD && cmd <= GAIN_LAST_CMD) begin
      result.write_kind   = KIND_GAIN;
      result.target_index = gain_idx[3:0];
      result.first_word   = {b0, b1};
    end else if (cmd >= MOTOR_FIRST_CMD && cmd <= MOTOR_LAST_CMD) begin
      result.write_kind   = KIND_MOTOR;
      result.target_index = motor_idx[3:0];
      result.first_word   = {b0, b1};
      result.second_word  = {b2, last_byte};
    end
  end

endmodule

`default_nettype wire

FILE: design/sync_framed_command_deframer.sv
// Top level of the sync-framed command deframer: framing state, input and
// result registers, config registers. Depends on sfcd_pkg and sfcd_decode.
//
// Usage:
//  - Input channel (rx_byte, in_valid, in_stall): one received byte per
//    transfer. Frame = first sync, second sync, command (< 100), 4 payload.
//  - Output channel (out_valid, out_stall): one decoded write per frame,
//    on the fourth payload byte. Other bytes yield nothing.
//  - APB port: reg 0 at 0x0 = first sync byte, reg 1 at 0x4 = second sync
//    byte. Write only while idle.
//  - Throughput: one byte per cycle while no frame-ending byte waits on a
//    busy result slot. The input register takes a byte each cycle unless
//    stalled; the framing FSM consumes it from there. The last payload byte
//    passes the input register and is decoded into the result register.
//  - Receiver stall: the result register holds. Bytes that end no frame
//    keep flowing; a frame-ending byte waits in the input register and
//    in_stall rises until the result slot frees.
//  - Reset (rst, sync): hunting first sync, counter zero, both registers
//    empty, sync bytes back to 79 / 75.
//  - A wrong second sync byte returns to hunting and is not reused as a
//    first sync byte. Rejected sensor frames do not bump the count.
`timescale 1ns / 1ps
`default_nettype none

module sync_framed_command_deframer
  import sfcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // APB config
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  // byte input
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire logic               in_valid,
  output logic                    in_stall,
  // decoded write output
  output logic [2:0]              write_kind,
  output logic [3:0]              target_index,
  output logic [31:0]             float_bits,
  output logic [15:0]             first_word,
  output logic [15:0]             second_word,
  output logic [BYTE_W-1:0]       first_byte,
  output logic [COUNT_W-1:0]      accepted_count,
  output logic                    out_valid,
  input  wire logic               out_stall
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC1   = 2'd1,
    PH_SYNC2   = 2'd2,
    PH_COLLECT = 2'd3
  } phase_t;

  // config registers
  logic [BYTE_W-1:0] first_sync_byte;
  logic [BYTE_W-1:0] second_sync_byte;
  logic              cfg_write;

  // input register
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;

  // framing state
  phase_t             frame_phase;
  logic [1:0]         payload_position;
  logic [CMD_W-1:0]   command_number;
  logic [23:0]        payload_buffer;   // no reset: written before read
  logic [COUNT_W-1:0] frame_counter;

  // result register
  result_t result;
  result_t decoded;

  logic frame_done;   // byte in the input register ends a frame
  logic out_free;
  logic advance;      // byte in the input register is consumed this cycle

  // ---------------------------------------------------------------------
  // APB: pready tied high, paddr[2] picks the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync_byte  <= FIRST_SYNC_RESET;
      second_sync_byte <= SECOND_SYNC_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FIRST_SYNC) begin
        first_sync_byte <= pwdata[BYTE_W-1:0];
      end else begin
        second_sync_byte <= pwdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SECOND_SYNC) begin
      prdata[BYTE_W-1:0] = second_sync_byte;
    end else begin
      prdata[BYTE_W-1:0] = first_sync_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. Only a frame-ending byte needs the result slot.
  assign frame_done = in_full && (frame_phase == PH_COLLECT) && (payload_position == 2'd3);
  assign out_free   = !out_valid || !out_stall;
  assign advance    = in_full && (!frame_done || out_free);
  assign in_stall   = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Decode of the completed frame
  sfcd_decode u_decode (
    .cmd       (command_number),
    .payload   (payload_buffer),
    .last_byte (in_byte),
    .count     (frame_counter),
    .result    (decoded)
  );

  // ---------------------------------------------------------------------
  // Framing FSM, counter, payload buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase      <= PH_HUNT;
      payload_position <= 2'd0;
      command_number   <= '0;
      frame_counter    <= '0;
    end else if (advance) begin
      case (frame_phase)
        PH_HUNT: begin
          if (in_byte == first_sync_byte) begin
            frame_phase <= PH_SYNC1;
          end
        end
        PH_SYNC1: begin
          frame_phase <= (in_byte == second_sync_byte) ? PH_SYNC2 : PH_HUNT;
        end
        PH_SYNC2: begin
          if (in_byte < CMD_LIMIT) begin
            command_number   <= in_byte[CMD_W-1:0];
            payload_position <= 2'd0;
            frame_phase      <= PH_COLLECT;
          end else begin
            frame_phase <= PH_HUNT;
          end
        end
        PH_COLLECT: begin
          if (payload_position == 2'd3) begin
            frame_phase      <= PH_HUNT;
            payload_position <= 2'd0;
            frame_counter    <= decoded.accepted_count;
          end else begin
            payload_position <= payload_position + 2'd1;
          end
        end
        default: frame_phase <= PH_HUNT;
      endcase
    end
    if (advance && frame_phase == PH_COLLECT && payload_position != 2'd3) begin
      payload_buffer[payload_position*BYTE_W +: BYTE_W] <= in_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && frame_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && frame_done) begin
      result <= decoded;
    end
  end

  assign write_kind     = result.write_kind;
  assign target_index   = result.target_index;
  assign float_bits     = result.float_bits;
  assign first_word     = result.first_word;
  assign second_word    = result.second_word;
  assign first_byte     = result.first_byte;
  assign accepted_count = result.accepted_count;

  // ---------------------------------------------------------------------
  // Assertions

  // a waiting result always matches the live counter: no frame may finish
  // behind a held result
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accepted_count == frame_counter)
    else $error("result count differs from frame counter");

  // payload position only moves while collecting
  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    frame_phase != PH_COLLECT |-> payload_position == 2'd0)
    else $error("payload position nonzero outside collection");

  // a rejected sensor frame leaves the count alone
  a_reject_no_count: assert property (@(posedge clk) disable iff (rst)
    advance && frame_done && decoded.write_kind == KIND_REJECT
      |=> $stable(frame_counter))
    else $error("rejected frame changed the count");

  // frame-ending byte held back only while the result slot is busy
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> frame_done && out_valid && out_stall)
    else $error("input stalled without a busy result slot");

endmodule

`default_nettype wire
